FILE: design/ctt_pkg.sv
// Shared types, codes and field layouts of the channel translation table.
`default_nettype none

package ctt_pkg;

   // Request and response field widths at the ports
   localparam int COMMAND_W  = 2;
   localparam int CHANNEL_W  = 32;
   localparam int HANDLE_W   = 16;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 56;

   // Configuration port
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int REG_INDEX_W = CSR_ADDR_W - 2;
   localparam logic [REG_INDEX_W-1:0] REG_RANDOM_SEED = 1'd0;

   // Random id generator
   localparam int LFSR_W = 32;
   localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'h8020_0003;

   // Command codes
   localparam logic [COMMAND_W-1:0] CMD_ADD    = 2'd0;
   localparam logic [COMMAND_W-1:0] CMD_LOOKUP = 2'd1;
   localparam logic [COMMAND_W-1:0] CMD_REMOVE = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_UNKNOWN = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

   typedef struct packed {
      logic [REQ_DATA_W-COMMAND_W-CHANNEL_W-HANDLE_W-1:0] pad;
      logic [HANDLE_W-1:0]                                cipher_handle;
      logic [CHANNEL_W-1:0]                               channel_in;
      logic [COMMAND_W-1:0]                               command;
   } req_data_type;

   typedef struct packed {
      logic [RSP_DATA_W-STATUS_W-CHANNEL_W-HANDLE_W-1:0] pad;
      logic [HANDLE_W-1:0]                               found_cipher;
      logic [CHANNEL_W-1:0]                              out_channel;
      logic [STATUS_W-1:0]                               status;
   } rsp_data_type;

   // Kinds of sweep over the table
   typedef enum logic [2:0] {
      PASS_CLEAR,
      PASS_CHECK,
      PASS_FIND,
      PASS_INC,
      PASS_DEC
   } pass_mode_type;

   // Kinds of response
   typedef enum logic [2:0] {
      RSP_ADDED,
      RSP_FOUND,
      RSP_REMOVED,
      RSP_UNKNOWN,
      RSP_FULL
   } rsp_kind_type;

   typedef struct packed {
      logic          load_req;
      logic          scan_start;
      pass_mode_type scan_mode;
      logic          lfsr_step;
      logic          write_entry;
      logic          clear_valid;
      logic          load_rsp;
      rsp_kind_type  rsp_kind;
   } ctt_cmd_type;

   typedef struct packed {
      logic                 pass_done;
      logic [COMMAND_W-1:0] command;
      logic                 free_found;
      logic                 collide;
      logic                 last_draw;
      logic                 match_found;
      logic                 out_free;
   } ctt_stat_type;

endpackage

`default_nettype wire

FILE: design/ctt_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module ctt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/ctt_ctrl.sv
// Sequencing state machine of the channel translation table.
`default_nettype none

module ctt_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire ctt_pkg::ctt_stat_type stat,
   output ctt_pkg::ctt_cmd_type       cmd
);

   import ctt_pkg::*;

   localparam logic [3:0] S_INIT     = 4'd0;
   localparam logic [3:0] S_CLEAR    = 4'd1;
   localparam logic [3:0] S_IDLE     = 4'd2;
   localparam logic [3:0] S_DISPATCH = 4'd3;
   localparam logic [3:0] S_CHECK    = 4'd4;
   localparam logic [3:0] S_INC      = 4'd5;
   localparam logic [3:0] S_WRITE    = 4'd6;
   localparam logic [3:0] S_FIND     = 4'd7;
   localparam logic [3:0] S_DEC      = 4'd8;
   localparam logic [3:0] S_REPLY    = 4'd9;

   logic [3:0]   state_ff;
   logic [3:0]   state_in;
   rsp_kind_type kind_ff;
   rsp_kind_type kind_in;

   always_comb begin
      state_in        = state_ff;
      kind_in         = kind_ff;
      req_tready      = 1'b0;
      cmd             = '0;
      cmd.scan_mode   = PASS_CLEAR;
      cmd.rsp_kind    = kind_ff;
      unique case (state_ff)
         S_INIT: begin
            cmd.scan_start = 1'b1;
            cmd.scan_mode  = PASS_CLEAR;
            state_in       = S_CLEAR;
         end
         S_CLEAR: begin
            if (stat.pass_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            priority if (stat.command == CMD_ADD) begin
               cmd.scan_start = 1'b1;
               cmd.scan_mode  = PASS_CHECK;
               state_in       = S_CHECK;
            end else if (stat.command == CMD_LOOKUP || stat.command == CMD_REMOVE) begin
               cmd.scan_start = 1'b1;
               cmd.scan_mode  = PASS_FIND;
               state_in       = S_FIND;
            end else begin
               kind_in  = RSP_UNKNOWN;
               state_in = S_REPLY;
            end
         end
         S_CHECK: begin
            if (stat.pass_done) begin
               priority if (!stat.free_found) begin
                  kind_in  = RSP_FULL;
                  state_in = S_REPLY;
               end else if (stat.collide) begin
                  // consume the draw; retry unless the draw budget is spent
                  cmd.lfsr_step = 1'b1;
                  if (stat.last_draw) begin
                     kind_in  = RSP_FULL;
                     state_in = S_REPLY;
                  end else begin
                     cmd.scan_start = 1'b1;
                     cmd.scan_mode  = PASS_CHECK;
                  end
               end else begin
                  cmd.lfsr_step  = 1'b1;
                  cmd.scan_start = 1'b1;
                  cmd.scan_mode  = PASS_INC;
                  state_in       = S_INC;
               end
            end
         end
         S_INC: begin
            if (stat.pass_done) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            cmd.write_entry = 1'b1;
            kind_in         = RSP_ADDED;
            state_in        = S_REPLY;
         end
         S_FIND: begin
            if (stat.pass_done) begin
               priority if (!stat.match_found) begin
                  kind_in  = RSP_UNKNOWN;
                  state_in = S_REPLY;
               end else if (stat.command == CMD_LOOKUP) begin
                  kind_in  = RSP_FOUND;
                  state_in = S_REPLY;
               end else begin
                  cmd.clear_valid = 1'b1;
                  cmd.scan_start  = 1'b1;
                  cmd.scan_mode   = PASS_DEC;
                  state_in        = S_DEC;
               end
            end
         end
         S_DEC: begin
            if (stat.pass_done) begin
               kind_in  = RSP_REMOVED;
               state_in = S_REPLY;
            end
         end
         S_REPLY: begin
            if (stat.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         kind_ff  <= RSP_UNKNOWN;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/ctt_datapath.sv
// Table storage, sweep engine, id generator, seed register and response register.
`default_nettype none

module ctt_datapath #(
   parameter int TABLE_ENTRIES = 64,
   parameter int CHANNEL_BITS  = 32,
   parameter int HANDLE_BITS   = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire ctt_pkg::ctt_cmd_type               cmd,
   output ctt_pkg::ctt_stat_type                   stat,
   input  wire logic [ctt_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic      [ctt_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [ctt_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [ctt_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic      [ctt_pkg::CSR_DATA_W-1:0]     csr_prdata
);

   import ctt_pkg::*;

   localparam int IDX_W  = $clog2(TABLE_ENTRIES);
   localparam int AGE_W  = IDX_W;
   localparam int DRAW_W = $clog2(TABLE_ENTRIES + 2);

   typedef struct packed {
      logic [AGE_W-1:0]        age;
      logic [HANDLE_BITS-1:0]  handle;
      logic [CHANNEL_BITS-1:0] out_id;
      logic [CHANNEL_BITS-1:0] in_id;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // ---------------- configuration and id generator ----------------
   logic [REG_INDEX_W-1:0]  reg_index;
   logic                    seed_wr;
   logic [LFSR_W-1:0]       seed_ff, seed_in;
   logic [LFSR_W-1:0]       lfsr_ff, lfsr_in;
   logic [LFSR_W-1:0]       lfsr_next;
   logic [CHANNEL_BITS-1:0] cand;
   logic [CHANNEL_BITS-1:0] id_ff, id_in;
   logic [DRAW_W-1:0]       draws_ff, draws_in;

   assign reg_index = csr_paddr[CSR_ADDR_W-1:2];
   assign seed_wr   = csr_psel && csr_penable && csr_pwrite && (reg_index == REG_RANDOM_SEED);
   assign csr_prdata = (reg_index == REG_RANDOM_SEED) ? seed_ff : '0;

   assign lfsr_next = {1'b0, lfsr_ff[LFSR_W-1:1]} ^ (lfsr_ff[0] ? LFSR_TAPS : '0);
   assign cand      = CHANNEL_BITS'(lfsr_next);

   always_comb begin
      seed_in  = seed_wr ? csr_pwdata : seed_ff;
      lfsr_in  = lfsr_ff;
      if (seed_wr) begin
         lfsr_in = (csr_pwdata == '0) ? LFSR_W'(1) : csr_pwdata;
      end else if (cmd.lfsr_step) begin
         lfsr_in = lfsr_next;
      end
      id_in    = cmd.lfsr_step ? cand : id_ff;
      draws_in = draws_ff;
      if (cmd.load_req) begin
         draws_in = '0;
      end else if (cmd.lfsr_step) begin
         draws_in = draws_ff + 1'b1;
      end
   end

   // ---------------- captured request ----------------
   req_data_type            req_d;
   logic [COMMAND_W-1:0]    command_ff;
   logic [CHANNEL_BITS-1:0] cin_ff;
   logic [HANDLE_BITS-1:0]  hnd_ff;

   assign req_d = req_tdata;

   // ---------------- sweep engine ----------------
   logic          run_ff, run_in;
   logic [IDX_W-1:0] addr_ff, addr_in;
   logic          addr_last;
   logic          stage_ff;
   logic [IDX_W-1:0] idx_d_ff;
   logic          last_d_ff;
   logic          done_ff;
   pass_mode_type mode_ff, mode_in;

   assign addr_last = (addr_ff == IDX_W'(TABLE_ENTRIES - 1));

   always_comb begin
      run_in  = run_ff;
      addr_in = addr_ff;
      mode_in = mode_ff;
      if (cmd.scan_start) begin
         run_in  = 1'b1;
         addr_in = '0;
         mode_in = cmd.scan_mode;
      end else if (run_ff) begin
         run_in  = !addr_last;
         addr_in = addr_ff + 1'b1;
      end
   end

   // ---------------- table memories ----------------
   logic             vld_we;
   logic [IDX_W-1:0] vld_waddr;
   logic             vld_wdata;
   logic             vld_rd;
   logic             dat_we;
   logic [IDX_W-1:0] dat_waddr;
   entry_type        dat_wdata;
   entry_type        dat_rd;
   logic [ENTRY_W-1:0] dat_rd_raw;

   assign dat_rd = dat_rd_raw;

   ctt_ram #(
      .WIDTH (1),
      .DEPTH (TABLE_ENTRIES)
   ) u_valid_ram (
      .clock   (clock),
      .wr_en   (vld_we),
      .wr_addr (vld_waddr),
      .wr_data (vld_wdata),
      .rd_addr (addr_ff),
      .rd_data (vld_rd)
   );

   ctt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (dat_we),
      .wr_addr (dat_waddr),
      .wr_data (dat_wdata),
      .rd_addr (addr_ff),
      .rd_data (dat_rd_raw)
   );

   // ---------------- per-sweep results ----------------
   logic                    free_found_ff, free_found_in;
   logic [IDX_W-1:0]        free_idx_ff, free_idx_in;
   logic                    collide_ff, collide_in;
   logic                    match_ff, match_in;
   logic [IDX_W-1:0]        match_idx_ff, match_idx_in;
   logic [AGE_W-1:0]        best_age_ff, best_age_in;
   logic [HANDLE_BITS-1:0]  best_hnd_ff, best_hnd_in;
   logic [CHANNEL_BITS-1:0] best_out_ff, best_out_in;

   always_comb begin
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      collide_in    = collide_ff;
      match_in      = match_ff;
      match_idx_in  = match_idx_ff;
      best_age_in   = best_age_ff;
      best_hnd_in   = best_hnd_ff;
      best_out_in   = best_out_ff;
      vld_we        = 1'b0;
      vld_waddr     = idx_d_ff;
      vld_wdata     = 1'b0;
      dat_we        = 1'b0;
      dat_waddr     = idx_d_ff;
      dat_wdata     = dat_rd;

      if (cmd.scan_start && cmd.scan_mode == PASS_CHECK) begin
         free_found_in = 1'b0;
         collide_in    = 1'b0;
      end
      if (cmd.scan_start && cmd.scan_mode == PASS_FIND) begin
         match_in = 1'b0;
      end

      if (stage_ff) begin
         unique case (mode_ff)
            PASS_CLEAR: begin
               vld_we = 1'b1;
            end
            PASS_CHECK: begin
               if (!vld_rd && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = idx_d_ff;
               end
               if (vld_rd && dat_rd.out_id == cand) begin
                  collide_in = 1'b1;
               end
            end
            PASS_FIND: begin
               if (vld_rd && dat_rd.in_id == cin_ff &&
                   (!match_ff || dat_rd.age < best_age_ff)) begin
                  match_in     = 1'b1;
                  match_idx_in = idx_d_ff;
                  best_age_in  = dat_rd.age;
                  best_hnd_in  = dat_rd.handle;
                  best_out_in  = dat_rd.out_id;
               end
            end
            PASS_INC: begin
               // age every live entry by one
               dat_we        = vld_rd;
               dat_wdata.age = dat_rd.age + 1'b1;
            end
            PASS_DEC: begin
               // close the gap left by the removed entry
               dat_we        = vld_rd && (dat_rd.age > best_age_ff);
               dat_wdata.age = dat_rd.age - 1'b1;
            end
            default: begin
            end
         endcase
      end

      if (cmd.write_entry) begin
         vld_we           = 1'b1;
         vld_waddr        = free_idx_ff;
         vld_wdata        = 1'b1;
         dat_we           = 1'b1;
         dat_waddr        = free_idx_ff;
         dat_wdata.age    = '0;
         dat_wdata.handle = hnd_ff;
         dat_wdata.out_id = id_ff;
         dat_wdata.in_id  = cin_ff;
      end
      if (cmd.clear_valid) begin
         vld_we    = 1'b1;
         vld_waddr = match_idx_ff;
         vld_wdata = 1'b0;
      end
   end

   // ---------------- response register ----------------
   logic                 out_free;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [CHANNEL_W-1:0] rsp_chan_ff, rsp_chan_in;
   logic [HANDLE_W-1:0]  rsp_cipher_ff, rsp_cipher_in;
   rsp_data_type         rsp_d;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_chan_in   = rsp_chan_ff;
      rsp_cipher_in = rsp_cipher_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = STATUS_OK;
         rsp_chan_in   = '0;
         rsp_cipher_in = '0;
         unique case (cmd.rsp_kind)
            RSP_ADDED: begin
               rsp_chan_in = CHANNEL_W'(id_ff);
            end
            RSP_FOUND: begin
               rsp_chan_in   = CHANNEL_W'(best_out_ff);
               rsp_cipher_in = HANDLE_W'(best_hnd_ff);
            end
            RSP_REMOVED: begin
               rsp_cipher_in = HANDLE_W'(best_hnd_ff);
            end
            RSP_FULL: begin
               rsp_status_in = STATUS_FULL;
            end
            default: begin
               rsp_status_in = STATUS_UNKNOWN;
            end
         endcase
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_d              = '0;
      rsp_d.status       = rsp_status_ff;
      rsp_d.out_channel  = rsp_chan_ff;
      rsp_d.found_cipher = rsp_cipher_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_d;

   // ---------------- status to the controller ----------------
   always_comb begin
      stat             = '0;
      stat.pass_done   = done_ff;
      stat.command     = command_ff;
      stat.free_found  = free_found_ff;
      stat.collide     = collide_ff;
      stat.last_draw   = (draws_ff == DRAW_W'(TABLE_ENTRIES));
      stat.match_found = match_ff;
      stat.out_free    = out_free;
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff       <= LFSR_W'(1);
         lfsr_ff       <= LFSR_W'(1);
         run_ff        <= 1'b0;
         stage_ff      <= 1'b0;
         last_d_ff     <= 1'b0;
         done_ff       <= 1'b0;
         free_found_ff <= 1'b0;
         collide_ff    <= 1'b0;
         match_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         seed_ff       <= seed_in;
         lfsr_ff       <= lfsr_in;
         run_ff        <= run_in;
         stage_ff      <= run_ff;
         last_d_ff     <= run_ff && addr_last;
         done_ff       <= stage_ff && last_d_ff;
         free_found_ff <= free_found_in;
         collide_ff    <= collide_in;
         match_ff      <= match_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         command_ff <= req_d.command;
         cin_ff     <= CHANNEL_BITS'(req_d.channel_in);
         hnd_ff     <= HANDLE_BITS'(req_d.cipher_handle);
      end
      id_ff         <= id_in;
      draws_ff      <= draws_in;
      addr_ff       <= addr_in;
      mode_ff       <= mode_in;
      idx_d_ff      <= addr_ff;
      free_idx_ff   <= free_idx_in;
      match_idx_ff  <= match_idx_in;
      best_age_ff   <= best_age_in;
      best_hnd_ff   <= best_hnd_in;
      best_out_ff   <= best_out_in;
      rsp_status_ff <= rsp_status_in;
      rsp_chan_ff   <= rsp_chan_in;
      rsp_cipher_ff <= rsp_cipher_in;
   end

   // ---------------- assertions ----------------
   assert property (@(posedge clock) disable iff (reset)
      cmd.scan_start |-> (!run_ff && !stage_ff))
      else $error("sweep started while another sweep is in flight");

   assert property (@(posedge clock) disable iff (reset)
      cmd.write_entry |-> free_found_ff)
      else $error("entry written without a free slot");

   assert property (@(posedge clock) disable iff (reset)
      cmd.clear_valid |-> match_ff)
      else $error("entry removed without a match");

   assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> out_free)
      else $error("response loaded over an undelivered response");

   assert property (@(posedge clock) disable iff (reset)
      lfsr_ff != '0)
      else $error("id generator reached the all-zero state");

endmodule

`default_nettype wire

FILE: design/channel_translation_table.sv
// Top level of the channel translation table: controller, datapath and port wiring.
//
// The block keeps up to TABLE_ENTRIES mappings from an incoming channel id to a
// randomly drawn outgoing channel id and a cipher handle. Each request on the
// req_ stream carries a command (add, lookup, remove); each yields exactly one
// response on the rsp_ stream with a status (success, id unknown, table full).
// Add draws ids from a 32-bit Galois LFSR (seeded through the random_seed
// register at byte address 0, a zero seed loads 1) until one differs from every
// stored outgoing id (if its draw budget runs out first, it answers table
// full), stores the entry in the lowest free slot and returns that id; lookup
// returns the outgoing id and handle of the newest entry with the given
// incoming id; remove deletes that entry and returns its handle. The table
// lives in two single-write, registered-read RAMs and every table operation is
// a sweep that visits one slot per cycle, so the table RAM port sets the rate:
// one request is in work at a time. The controller returns to idle and takes
// the next request once the response is loaded, even while that response still
// waits in the output register; a later response that finds the register
// occupied holds the controller until the receiver takes the old one. After
// reset a clearing pass empties the table before the first request is taken;
// configuration writes are accepted throughout.
`default_nettype none

module channel_translation_table #(
   parameter int TABLE_ENTRIES = 64,
   parameter int CHANNEL_BITS  = 32,
   parameter int HANDLE_BITS   = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request stream
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // [1:0] command, [33:2] channel_in, [49:34] cipher_handle, [55:50] zero
   input  wire logic [ctt_pkg::REQ_DATA_W-1:0] req_tdata,
   // response stream
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // [1:0] status, [33:2] out_channel, [49:34] found_cipher, [55:50] zero
   output logic      [ctt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // configuration port
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [ctt_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [ctt_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [ctt_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                csr_pready
);

   import ctt_pkg::*;

   ctt_cmd_type  cmd;
   ctt_stat_type stat;

   // Register access never waits.
   assign csr_pready = 1'b1;

   // Sequence each request through its sweeps.
   ctt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Hold the table, the id generator, the seed and the response.
   ctt_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .CHANNEL_BITS  (CHANNEL_BITS),
      .HANDLE_BITS   (HANDLE_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata)
   );

endmodule

`default_nettype wire
